### sv/edge_pair_bloom_filter_defines.svh
// Assertion macros used by the checker file of the bloom filter block.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef EDGE_PAIR_BLOOM_FILTER_DEFINES_SVH
`define EDGE_PAIR_BLOOM_FILTER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent
`define EPBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epbf: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent
`define EPBF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epbf: same-cycle check failed");

`endif

### sv/epbf_pkg.sv
package epbf_pkg;

    // sizing of the bit store and of the hash set
    localparam int FILTER_BITS = 65536;
    localparam int MAX_HASHES  = 4;
    localparam int MULT_REGS   = 4;
    localparam int HASH_LIMIT  = (MAX_HASHES < MULT_REGS) ? MAX_HASHES : MULT_REGS;

    // field widths
    localparam int VERTEX_W = 31;
    localparam int MULT_W   = 32;
    localparam int SIZE_W   = 17;
    localparam int HCNT_W   = 3;
    localparam int OP_W     = 2;

    // bit positions and effective modulus
    localparam int POS_W = $clog2(FILTER_BITS);
    localparam int ESZ_W = POS_W + 1;

    // bit store organised as rows of bits
    localparam int ROW_W     = 32;
    localparam int ROW_SEL_W = $clog2(ROW_W);
    localparam int ROWS      = FILTER_BITS / ROW_W;
    localparam int ROW_AW    = $clog2(ROWS);

    // hash arithmetic: product, dividend and radix-16 remainder steps
    localparam int PROD_W     = VERTEX_W + MULT_W;
    localparam int DIVD_W     = PROD_W + 1;
    localparam int RADIX_BITS = 4;
    localparam int DIV_STEPS  = DIVD_W / RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int HASH_IDX_W = $clog2(MULT_REGS);

    // configuration port
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_EMPTY  = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SIZE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HCNT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MULT0 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MULT1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MULT2 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MULT3 = 3'd5;

    // request to the hash unit
    typedef struct packed {
        logic                start;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] nbr;
        logic [MULT_W-1:0]   mult;
        logic [ESZ_W-1:0]    size;
    } hash_req_t;

    // answer from the hash unit
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] pos;
    } hash_rsp_t;

endpackage

### sv/edge_pair_bloom_filter.sv
// Bloom filter over vertex pairs, one word at a time. After reset the bit
// store is swept clear, one 32-bit row a cycle, and no word is taken until
// the sweep ends (register writes are taken throughout). Each insert or
// query word runs the hash unit once per hash in use: a multiply, an add
// and a 16-step radix-16 remainder, followed by a read of the row in the
// single-port bit store and, for inserts, a write-back of the row. A query
// word ending a run and an empty query post their answer through the result
// state; a word with the unused opcode is taken and dropped. A finished
// answer waits in the output register while the next word is taken.
module edge_pair_bloom_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [epbf_pkg::PADDR_W-1:0]      paddr,
    input  logic [epbf_pkg::DATA_W-1:0]       pwdata,
    output logic [epbf_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [epbf_pkg::OP_W-1:0]         opcode,
    input  logic [epbf_pkg::VERTEX_W-1:0]     source_vertex,
    input  logic [epbf_pkg::VERTEX_W-1:0]     neighbor_vertex,
    input  logic                              last_of_list,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              filtered
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_RESULT
    } state_t;

    // configuration registers
    logic [epbf_pkg::SIZE_W-1:0]      size_cfg_reg;
    logic [epbf_pkg::HCNT_W-1:0]      hcnt_cfg_reg;
    logic [epbf_pkg::MULT_W-1:0]      mult_cfg_reg [epbf_pkg::MULT_REGS];
    logic [epbf_pkg::REG_IDX_W-1:0]   cfg_idx;
    logic                             cfg_wr;
    logic [epbf_pkg::ESZ_W-1:0]       eff_size;
    logic [epbf_pkg::HCNT_W-1:0]      eff_hashes;

    // control and word registers
    state_t                           state_reg;
    logic [epbf_pkg::ROW_AW-1:0]      clr_cnt_reg;
    logic                             hash_start_reg;
    logic                             hash_start_next;
    logic                             seen_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             filtered_reg;
    logic                             res_reg;
    logic [epbf_pkg::HCNT_W-1:0]      k_reg;
    logic [epbf_pkg::HCNT_W-1:0]      nhash_reg;
    logic [epbf_pkg::OP_W-1:0]        op_reg;
    logic [epbf_pkg::VERTEX_W-1:0]    src_reg;
    logic [epbf_pkg::VERTEX_W-1:0]    nbr_reg;
    logic                             last_reg;
    logic [epbf_pkg::POS_W-1:0]       pos_reg;
    logic                             all_set_reg;

    // combinational helpers
    logic [epbf_pkg::HCNT_W-1:0]      k_next;
    logic                             more_hash;
    logic                             cur_bit;
    logic                             all_set_c;
    logic                             seen_c;

    // bit store port
    logic                             mem_en;
    logic                             mem_we;
    logic [epbf_pkg::ROW_AW-1:0]      mem_addr;
    logic [epbf_pkg::ROW_W-1:0]       mem_wdata;
    logic [epbf_pkg::ROW_W-1:0]       mem_rdata;

    epbf_pkg::hash_req_t              hreq;
    epbf_pkg::hash_rsp_t              hrsp;

    // register port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[epbf_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg    <= epbf_pkg::SIZE_W'(65536);
            hcnt_cfg_reg    <= epbf_pkg::HCNT_W'(4);
            mult_cfg_reg[0] <= epbf_pkg::MULT_W'(1);
            mult_cfg_reg[1] <= epbf_pkg::MULT_W'(3);
            mult_cfg_reg[2] <= epbf_pkg::MULT_W'(5);
            mult_cfg_reg[3] <= epbf_pkg::MULT_W'(7);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                epbf_pkg::REG_SIZE:  size_cfg_reg    <= pwdata[epbf_pkg::SIZE_W-1:0];
                epbf_pkg::REG_HCNT:  hcnt_cfg_reg    <= pwdata[epbf_pkg::HCNT_W-1:0];
                epbf_pkg::REG_MULT0: mult_cfg_reg[0] <= pwdata;
                epbf_pkg::REG_MULT1: mult_cfg_reg[1] <= pwdata;
                epbf_pkg::REG_MULT2: mult_cfg_reg[2] <= pwdata;
                epbf_pkg::REG_MULT3: mult_cfg_reg[3] <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            epbf_pkg::REG_SIZE:  prdata = epbf_pkg::DATA_W'(size_cfg_reg);
            epbf_pkg::REG_HCNT:  prdata = epbf_pkg::DATA_W'(hcnt_cfg_reg);
            epbf_pkg::REG_MULT0: prdata = mult_cfg_reg[0];
            epbf_pkg::REG_MULT1: prdata = mult_cfg_reg[1];
            epbf_pkg::REG_MULT2: prdata = mult_cfg_reg[2];
            epbf_pkg::REG_MULT3: prdata = mult_cfg_reg[3];
            default:             prdata = '0;
        endcase
    end

    // clamp modulus and hash count into their working ranges
    always_comb
    begin
        if (size_cfg_reg == '0)
        begin
            eff_size = epbf_pkg::ESZ_W'(1);
        end
        else if (32'(size_cfg_reg) > 32'(epbf_pkg::FILTER_BITS))
        begin
            eff_size = epbf_pkg::ESZ_W'(epbf_pkg::FILTER_BITS);
        end
        else
        begin
            eff_size = epbf_pkg::ESZ_W'(size_cfg_reg);
        end

        if (hcnt_cfg_reg == '0)
        begin
            eff_hashes = epbf_pkg::HCNT_W'(1);
        end
        else if (32'(hcnt_cfg_reg) > 32'(epbf_pkg::HASH_LIMIT))
        begin
            eff_hashes = epbf_pkg::HCNT_W'(epbf_pkg::HASH_LIMIT);
        end
        else
        begin
            eff_hashes = hcnt_cfg_reg;
        end
    end

    // hash unit
    assign hreq.start = hash_start_reg;
    assign hreq.src   = src_reg;
    assign hreq.nbr   = nbr_reg;
    assign hreq.mult  = mult_cfg_reg[k_reg[epbf_pkg::HASH_IDX_W-1:0]];
    assign hreq.size  = eff_size;

    epbf_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp)
    );

    // bit store
    epbf_ram #(
        .WIDTH (epbf_pkg::ROW_W),
        .DEPTH (epbf_pkg::ROWS)
    ) u_bits (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // bit of the row just read, and the running answer of this word
    assign cur_bit   = mem_rdata[pos_reg[epbf_pkg::ROW_SEL_W-1:0]];
    assign all_set_c = all_set_reg & cur_bit;
    assign seen_c    = seen_reg | all_set_c;
    assign k_next    = k_reg + epbf_pkg::HCNT_W'(1);
    assign more_hash = (k_next < nhash_reg);

    // hash start on a taken insert or query word, and after each checked hash but the last
    assign hash_start_next = ((state_reg == S_IDLE) && in_valid
                              && (opcode inside {epbf_pkg::OP_INSERT, epbf_pkg::OP_QUERY}))
                             || ((state_reg == S_CHECK) && more_hash);

    // answer register: loaded from the result state, cleared once taken
    assign out_valid_next = (state_reg == S_RESULT) || (out_valid_reg && !out_ready);

    // store access: sweep, row read on hash done, write-back for inserts
    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = pos_reg[epbf_pkg::POS_W-1:epbf_pkg::ROW_SEL_W];
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            S_HASH:
            begin
                mem_en   = hrsp.done;
                mem_addr = hrsp.pos[epbf_pkg::POS_W-1:epbf_pkg::ROW_SEL_W];
            end
            S_CHECK:
            begin
                if (op_reg == epbf_pkg::OP_INSERT)
                begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata
                        | (epbf_pkg::ROW_W'(1) << pos_reg[epbf_pkg::ROW_SEL_W-1:0]);
                end
            end
            default:
            begin
            end
        endcase
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            hash_start_reg <= 1'b0;
            seen_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            filtered_reg   <= 1'b0;
            res_reg        <= 1'b0;
            k_reg          <= '0;
            nhash_reg      <= '0;
            op_reg         <= '0;
            src_reg        <= '0;
            nbr_reg        <= '0;
            last_reg       <= 1'b0;
            pos_reg        <= '0;
            all_set_reg    <= 1'b0;
        end
        else
        begin
            hash_start_reg <= hash_start_next;
            out_valid_reg  <= out_valid_next;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + epbf_pkg::ROW_AW'(1);
                    if (clr_cnt_reg == epbf_pkg::ROW_AW'(epbf_pkg::ROWS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= opcode;
                        src_reg     <= source_vertex;
                        nbr_reg     <= neighbor_vertex;
                        last_reg    <= last_of_list;
                        nhash_reg   <= eff_hashes;
                        k_reg       <= '0;
                        all_set_reg <= 1'b1;
                        case (opcode)
                            epbf_pkg::OP_INSERT, epbf_pkg::OP_QUERY:
                            begin
                                state_reg <= S_HASH;
                            end
                            epbf_pkg::OP_EMPTY:
                            begin
                                seen_reg  <= 1'b0;
                                res_reg   <= 1'b1;
                                state_reg <= S_RESULT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_HASH:
                begin
                    if (hrsp.done)
                    begin
                        pos_reg   <= hrsp.pos;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (more_hash)
                    begin
                        k_reg       <= k_next;
                        all_set_reg <= all_set_c;
                        state_reg   <= S_HASH;
                    end
                    else if (op_reg == epbf_pkg::OP_QUERY)
                    begin
                        if (last_reg)
                        begin
                            res_reg   <= !seen_c;
                            seen_reg  <= 1'b0;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            seen_reg  <= seen_c;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RESULT:
                begin
                    // post once the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        filtered_reg <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

endmodule

### sv/epbf_ram.sv
module epbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, read data registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/epbf_hash.sv
// Hash position unit: (nbr * mult + src) mod size.
// A multiply state, an add state, then a radix-16 remainder over
// the 64-bit dividend, four bits a cycle.
module epbf_hash (
    input  logic                clk,
    input  logic                rst_n,
    input  epbf_pkg::hash_req_t req,
    output epbf_pkg::hash_rsp_t rsp
);

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_ADD,
        H_DIV
    } hstate_t;

    hstate_t                          state_reg;
    logic [epbf_pkg::STEP_W-1:0]      step_reg;
    logic                             done_reg;
    logic                             done_next;

    logic [epbf_pkg::VERTEX_W-1:0]    src_reg;
    logic [epbf_pkg::VERTEX_W-1:0]    nbr_reg;
    logic [epbf_pkg::MULT_W-1:0]      mult_reg;
    logic [epbf_pkg::ESZ_W-1:0]       size_reg;
    logic [epbf_pkg::PROD_W-1:0]      prod_reg;
    logic [epbf_pkg::DIVD_W-1:0]      divd_reg;
    logic [epbf_pkg::POS_W-1:0]       rem_reg;
    logic [epbf_pkg::POS_W-1:0]       rem_next;

    logic [epbf_pkg::POS_W:0]         part_c;
    logic [epbf_pkg::POS_W:0]         trial_c;

    // four restoring remainder steps; remainder stays below the modulus
    always_comb
    begin
        part_c = {1'b0, rem_reg};
        for (int i = 0; i < epbf_pkg::RADIX_BITS; i++)
        begin
            trial_c = {part_c[epbf_pkg::POS_W-1:0], divd_reg[epbf_pkg::DIVD_W-1-i]};
            if (trial_c >= size_reg)
            begin
                trial_c = trial_c - size_reg;
            end
            part_c = trial_c;
        end
        rem_next = part_c[epbf_pkg::POS_W-1:0];
    end

    // done pulse follows the last remainder step
    assign done_next = (state_reg == H_DIV)
                       && (step_reg == epbf_pkg::STEP_W'(epbf_pkg::DIV_STEPS - 1));

    // operands and datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            H_IDLE:
            begin
                if (req.start)
                begin
                    src_reg  <= req.src;
                    nbr_reg  <= req.nbr;
                    mult_reg <= req.mult;
                    size_reg <= req.size;
                end
            end
            H_MUL:
            begin
                prod_reg <= epbf_pkg::PROD_W'(nbr_reg) * epbf_pkg::PROD_W'(mult_reg);
            end
            H_ADD:
            begin
                divd_reg <= epbf_pkg::DIVD_W'(prod_reg) + epbf_pkg::DIVD_W'(src_reg);
                rem_reg  <= '0;
            end
            H_DIV:
            begin
                divd_reg <= divd_reg << epbf_pkg::RADIX_BITS;
                rem_reg  <= rem_next;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            case (state_reg)
                H_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= H_MUL;
                    end
                end
                H_MUL:
                begin
                    state_reg <= H_ADD;
                end
                H_ADD:
                begin
                    step_reg  <= '0;
                    state_reg <= H_DIV;
                end
                H_DIV:
                begin
                    step_reg <= step_reg + epbf_pkg::STEP_W'(1);
                    if (step_reg == epbf_pkg::STEP_W'(epbf_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= H_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.pos  = rem_reg;

endmodule

### sv/epbf_checker.sv
`include "edge_pair_bloom_filter_defines.svh"

module epbf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [epbf_pkg::OP_W-1:0] opcode,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      filtered
);

    // a word taken on the input side
    logic in_take;

    assign in_take = in_valid && in_ready;

    // a waiting answer word holds
    `EPBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered))

    // an empty query keeps the block busy while its answer is posted
    `EPBF_ASSERT_NEXT(a_empty_busy, in_take && opcode == epbf_pkg::OP_EMPTY, !in_ready)

    // an insert never posts an answer
    `EPBF_ASSERT_NEXT(a_insert_silent, in_take && opcode == epbf_pkg::OP_INSERT, !$rose(out_valid))

    // answers are only posted from the busy side of the sequencer
    `EPBF_ASSERT_NOW(a_post_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind edge_pair_bloom_filter epbf_checker u_epbf_checker (.*);

### tb/edge_pair_bloom_filter_checker.sv
module edge_pair_bloom_filter_checker
    import epbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [OP_W-1:0]      opcode,
    input  logic [VERTEX_W-1:0]  source_vertex,
    input  logic [VERTEX_W-1:0]  neighbor_vertex,
    input  logic                 last_of_list,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 filtered,
    output int                   failures,
    output int                   pending,
    output int                   answers
);

    // shadow copy of the bit store, the open run and the registers
    bit                 pair_bits [FILTER_BITS];
    bit                 run_hit;
    logic [SIZE_W-1:0]  size_reg;
    logic [HCNT_W-1:0]  hcnt_reg;
    logic [MULT_W-1:0]  mult_reg [MULT_REGS];
    bit                 answers_due [$];

    // modulus actually applied: zero acts as one, oversize clamps to the store
    function automatic logic [ESZ_W-1:0] live_modulus();
        if (size_reg == '0)
            return ESZ_W'(1);
        if (size_reg > FILTER_BITS)
            return ESZ_W'(FILTER_BITS);
        return ESZ_W'(size_reg);
    endfunction

    // hashes actually applied: zero acts as one, clamp to the multiplier set
    function automatic int live_hashes();
        int count;
        count = int'(hcnt_reg);
        if (count == 0)
            count = 1;
        if (count > HASH_LIMIT)
            count = HASH_LIMIT;
        return count;
    endfunction

    // (neighbour * multiplier + source) mod modulus, exact in 64 bits
    function automatic logic [POS_W-1:0] pair_slot(
        input logic [VERTEX_W-1:0] src,
        input logic [VERTEX_W-1:0] nbr,
        input logic [MULT_W-1:0]   mult,
        input logic [ESZ_W-1:0]    modulus
    );
        logic [63:0] mixed;
        mixed = 64'(nbr) * 64'(mult) + 64'(src);
        return POS_W'(mixed % 64'(modulus));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict
        int                nhash;
        logic [ESZ_W-1:0]  modulus;
        bit                all_set;
        bit                want;
        logic [POS_W-1:0]  slot;

        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_BITS; i++)
                pair_bits[i] = 1'b0;
            run_hit     = 1'b0;
            size_reg    = SIZE_W'(65536);
            hcnt_reg    = HCNT_W'(4);
            mult_reg[0] = 32'd1;
            mult_reg[1] = 32'd3;
            mult_reg[2] = 32'd5;
            mult_reg[3] = 32'd7;
            answers_due.delete();
            failures    = 0;
            answers     = 0;
            pending     = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_SIZE:  size_reg    = pwdata[SIZE_W-1:0];
                    REG_HCNT:  hcnt_reg    = pwdata[HCNT_W-1:0];
                    REG_MULT0: mult_reg[0] = pwdata[MULT_W-1:0];
                    REG_MULT1: mult_reg[1] = pwdata[MULT_W-1:0];
                    REG_MULT2: mult_reg[2] = pwdata[MULT_W-1:0];
                    REG_MULT3: mult_reg[3] = pwdata[MULT_W-1:0];
                    default: ;
                endcase
            end

            // answers leaving the block
            if (out_valid && out_ready)
            begin
                answers++;
                if (answers_due.size() == 0)
                begin
                    failures++;
                    $display("%0t: filtered=%b arrived, none expected", $time, filtered);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (filtered !== want)
                    begin
                        failures++;
                        $display("%0t: filtered mismatch, expected %b, got %b",
                                 $time, want, filtered);
                    end
                end
            end

            // words entering the block
            if (in_valid && in_ready)
            begin
                nhash   = live_hashes();
                modulus = live_modulus();
                case (opcode)
                    OP_INSERT:
                    begin
                        for (int k = 0; k < nhash; k++)
                        begin
                            slot = pair_slot(source_vertex, neighbor_vertex, mult_reg[k], modulus);
                            pair_bits[slot] = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        all_set = 1'b1;
                        for (int k = 0; k < nhash; k++)
                        begin
                            slot = pair_slot(source_vertex, neighbor_vertex, mult_reg[k], modulus);
                            if (!pair_bits[slot])
                                all_set = 1'b0;
                        end
                        if (all_set)
                            run_hit = 1'b1;
                        if (last_of_list)
                        begin
                            answers_due.push_back(!run_hit);
                            run_hit = 1'b0;
                        end
                    end
                    OP_EMPTY:
                    begin
                        // abandons any open run
                        run_hit = 1'b0;
                        answers_due.push_back(1'b1);
                    end
                    default: ;
                endcase
            end

            pending = answers_due.size();
        end
    end

endmodule

### tb/tb_edge_pair_bloom_filter.sv
module tb_edge_pair_bloom_filter;
    import epbf_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPARE0  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE1  = 3'd7;
    localparam logic [VERTEX_W-1:0]  VMAX        = {VERTEX_W{1'b1}};
    localparam int                   IDLE_PCT    = 24;
    localparam int                   PHASE_WORDS = 130;
    localparam int                   SETTLE      = 200;
    localparam int                   STALL_LIMIT = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode;
    logic [VERTEX_W-1:0]  source_vertex;
    logic [VERTEX_W-1:0]  neighbor_vertex;
    logic                 last_of_list;
    logic                 out_valid;
    logic                 out_ready;
    logic                 filtered;

    int                   failures;
    int                   pending;
    int                   answers;
    int                   words_sent;
    int                   useful_words;
    int                   settings_used;
    int                   stuck_cycles;
    bit                   steady;
    logic [VERTEX_W-1:0]  known_src [$];
    logic [VERTEX_W-1:0]  known_nbr [$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    edge_pair_bloom_filter i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .source_vertex   (source_vertex),
        .neighbor_vertex (neighbor_vertex),
        .last_of_list    (last_of_list),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered        (filtered)
    );

    edge_pair_bloom_filter_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .source_vertex   (source_vertex),
        .neighbor_vertex (neighbor_vertex),
        .last_of_list    (last_of_list),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered        (filtered),
        .failures        (failures),
        .pending         (pending),
        .answers         (answers)
    );

    // vertex ids biased towards the extremes and small values that collide
    function automatic logic [VERTEX_W-1:0] random_vertex();
        case ($urandom_range(9))
            0: return '0;
            1: return VMAX;
            2, 3: return VERTEX_W'($urandom_range(15));
            default: return VERTEX_W'($urandom);
        endcase
    endfunction

    // present one word, optionally after idle cycles; returns at a falling edge
    task automatic send_word(
        input logic [OP_W-1:0]     op,
        input logic [VERTEX_W-1:0] src,
        input logic [VERTEX_W-1:0] nbr,
        input logic                last
    );
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        source_vertex   <= src;
        neighbor_vertex <= nbr;
        last_of_list    <= last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        words_sent++;
        if (op != OP_UNUSED)
            useful_words++;
        if (op == OP_INSERT)
        begin
            known_src.push_back(src);
            known_nbr.push_back(nbr);
        end
    endtask

    // half the time a recently inserted pair, else a fresh one
    task automatic pick_pair(output logic [VERTEX_W-1:0] src, output logic [VERTEX_W-1:0] nbr);
        int depth;
        int idx;
        depth = known_src.size();
        if (depth != 0 && $urandom_range(1) == 1)
        begin
            idx = depth - 1 - $urandom_range(((depth < 32) ? depth : 32) - 1);
            src = known_src[idx];
            nbr = known_nbr[idx];
        end
        else
        begin
            src = random_vertex();
            nbr = random_vertex();
        end
    endtask

    // well-formed query run, last word marked
    task automatic query_run(input int len);
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] nbr;
        for (int i = 0; i < len; i++)
        begin
            pick_pair(src, nbr);
            send_word(OP_QUERY, src, nbr, i == len - 1);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // drain all answers, then let any insert still hashing finish
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apply_setting(
        input logic [DATA_W-1:0] size_val,
        input logic [DATA_W-1:0] hcnt_val,
        input logic [DATA_W-1:0] m0,
        input logic [DATA_W-1:0] m1,
        input logic [DATA_W-1:0] m2,
        input logic [DATA_W-1:0] m3
    );
        settle();
        write_reg(REG_SIZE, size_val);
        write_reg(REG_HCNT, hcnt_val);
        write_reg(REG_MULT0, m0);
        write_reg(REG_MULT1, m1);
        write_reg(REG_MULT2, m2);
        write_reg(REG_MULT3, m3);
        settings_used++;
    endtask

    // mostly well-formed inserts and runs, some intruded or abandoned runs
    task automatic random_phase(input int count);
        int                  first;
        int                  kind;
        int                  len;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] nbr;
        first = useful_words;
        while (useful_words - first < count)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                len = $urandom_range(1, 3);
                repeat (len)
                    send_word(OP_INSERT, random_vertex(), random_vertex(), 1'($urandom));
            end
            else if (kind < 70)
                query_run(($urandom_range(3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3));
            else if (kind < 80)
                send_word(OP_EMPTY, random_vertex(), random_vertex(), 1'($urandom));
            else if (kind < 90)
            begin
                // run with an insert or an unused word inside; run stays open
                len = $urandom_range(2, 4);
                for (int i = 0; i < len; i++)
                begin
                    if (i == len - 1)
                    begin
                        if ($urandom_range(1) == 1)
                            send_word(OP_INSERT, random_vertex(), random_vertex(),
                                      1'($urandom));
                        else
                            send_word(OP_UNUSED, random_vertex(), random_vertex(),
                                      1'($urandom));
                    end
                    pick_pair(src, nbr);
                    send_word(OP_QUERY, src, nbr, i == len - 1);
                end
            end
            else
            begin
                // run abandoned by an empty query
                len = $urandom_range(1, 3);
                repeat (len)
                begin
                    pick_pair(src, nbr);
                    send_word(OP_QUERY, src, nbr, 1'b0);
                end
                send_word(OP_EMPTY, random_vertex(), random_vertex(), 1'($urandom));
            end
        end
    endtask

    // receiver: random stalls except in the steady phase
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no word, answer or register write moving
    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("timeout after %0d quiet cycles", STALL_LIMIT);
        $display("tb_edge_pair_bloom_filter: done, errors");
        $finish;
    end

    // stimulus
    initial
    begin
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_valid        <= 1'b0;
        opcode          <= OP_INSERT;
        source_vertex   <= '0;
        neighbor_vertex <= '0;
        last_of_list    <= 1'b0;
        steady          = 1'b0;
        words_sent      = 0;
        useful_words    = 0;
        settings_used   = 1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset settings
        send_word(OP_EMPTY, '0, '0, 1'b0);
        send_word(OP_QUERY, '0, '0, 1'b1);
        send_word(OP_INSERT, '0, '0, 1'b1);
        send_word(OP_QUERY, '0, '0, 1'b1);
        send_word(OP_INSERT, VMAX, VMAX, 1'b0);
        send_word(OP_QUERY, 31'd5, 31'd9, 1'b0);
        send_word(OP_QUERY, VMAX, VMAX, 1'b0);
        send_word(OP_QUERY, 31'd1, 31'd2, 1'b1);
        // insert inside an open run
        send_word(OP_QUERY, 31'd5, 31'd9, 1'b0);
        send_word(OP_INSERT, 31'd3, 31'd4, 1'b0);
        send_word(OP_QUERY, 31'd3, 31'd4, 1'b1);
        // hit abandoned by an empty query
        send_word(OP_QUERY, '0, '0, 1'b0);
        send_word(OP_EMPTY, VMAX, VMAX, 1'b1);
        send_word(OP_QUERY, 31'd6, 31'd7, 1'b1);
        // unused opcode, alone and inside a run
        send_word(OP_UNUSED, VMAX, VMAX, 1'b1);
        send_word(OP_QUERY, '0, '0, 1'b0);
        send_word(OP_UNUSED, '0, '0, 1'b1);
        send_word(OP_QUERY, 31'd1, 31'd1, 1'b1);
        send_word(OP_QUERY, VMAX, '0, 1'b1);
        send_word(OP_QUERY, '0, VMAX, 1'b1);
        send_word(OP_INSERT, VMAX, '0, 1'b0);
        send_word(OP_QUERY, VMAX, '0, 1'b1);
        random_phase(PHASE_WORDS);

        apply_setting(32'd65536, 32'd4, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h9E37_79B9);
        random_phase(PHASE_WORDS);

        apply_setting(32'd1, 32'd1, $urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_WORDS);

        // hash count above the multiplier set, with no idling anywhere
        apply_setting(32'd64, 32'd7, $urandom, $urandom, $urandom, $urandom);
        steady = 1'b1;
        random_phase(PHASE_WORDS);
        steady = 1'b0;

        // size masked down to zero, zero hashes, writes past the last register
        apply_setting(32'hFFFE_0000, 32'd0, $urandom, $urandom, $urandom, $urandom);
        write_reg(REG_SPARE0, $urandom);
        write_reg(REG_SPARE1, $urandom);
        random_phase(PHASE_WORDS);

        apply_setting(32'd65537, 32'd5, $urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_WORDS);

        apply_setting($urandom_range(2, 4096), 32'd2, $urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_WORDS);

        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_WORDS);

        apply_setting(32'd300, 32'd3, $urandom_range(3), $urandom_range(3),
                      $urandom_range(3), $urandom_range(3));
        random_phase(PHASE_WORDS);

        settle();
        $display("covered %0d words (%0d unused opcode) over %0d filter settings",
                 words_sent, words_sent - useful_words, settings_used);
        $display("%0d query answers compared, %0d mismatches", answers, failures);
        if (failures == 0)
            $display("tb_edge_pair_bloom_filter: done, clean");
        else
            $display("tb_edge_pair_bloom_filter: done, errors");
        $finish;
    end

endmodule
